@@ design/satd_pkg.sv @@
// Shared types and constants for the set-associative cache tag directory.
// Used by satd_ctrl, satd_datapath and set_assoc_cache_tag_directory; no dependencies.
package satd_pkg;

   // Fixed port widths
   localparam int ADDR_W      = 32;
   localparam int COUNT_W     = 32;
   localparam int REQ_TYPE_W  = 2;
   localparam int WAY_SEL_W   = 2;
   localparam int SET_SEL_W   = 6;
   localparam int WAY_OUT_W   = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 2;
   localparam int POLICY_W    = 2;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP    = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_FLUSH_ALL = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_INV_LINE  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_INV_WAY   = 2'd3;

   // Replacement policy codes
   localparam logic [POLICY_W-1:0] POLICY_ROUND_ROBIN = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_MRU_TOGGLE  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_RANDOM      = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_FROM_VIRT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAG_FROM_VIRT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACE_POLICY  = 2'd2;

   // Galois LFSR, x^32 + x^22 + x^2 + x + 1
   localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
   localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request, read tag rows
      logic execute;   // compare, fill or invalidate, update response
   } cmd_type;

endpackage

@@ design/satd_ctrl.sv @@
// Controller for the cache tag directory: two-state sequencer that drives
// the datapath commands and the response strobe. Depends on satd_pkg.
module satd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output satd_pkg::cmd_type cmd
);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   // Sequence: accept in idle, execute for one cycle, back to idle
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (start) state_in = STATE_EXEC;
         end
         STATE_EXEC: begin
            state_in = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   assign cmd.capture  = start && (state_ff == STATE_IDLE);
   assign cmd.execute  = (state_ff == STATE_EXEC);
   assign rsp_valid_in = cmd.execute;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff == STATE_EXEC);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/satd_datapath.sv @@
// Datapath for the cache tag directory: configuration registers, per-way tag
// memories, valid bits, victim selection and counters. Depends on satd_pkg.
module satd_datapath #(
   parameter int SETS       = 64,
   parameter int WAYS       = 4,
   parameter int LINE_BYTES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  satd_pkg::cmd_type                   cmd,
   input  logic                                csr_wr_en,
   input  logic [satd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [satd_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  logic [satd_pkg::REQ_TYPE_W-1:0]     req_type,
   input  logic [satd_pkg::ADDR_W-1:0]         req_phys_address,
   input  logic [satd_pkg::ADDR_W-1:0]         req_virt_address,
   input  logic [satd_pkg::WAY_SEL_W-1:0]      req_way_select,
   input  logic [satd_pkg::SET_SEL_W-1:0]      req_set_select,
   output logic                                rsp_hit,
   output logic [satd_pkg::WAY_OUT_W-1:0]      rsp_way_used,
   output logic [satd_pkg::COUNT_W-1:0]        rsp_hit_count,
   output logic [satd_pkg::COUNT_W-1:0]        rsp_miss_count
);

   localparam int OFF_BITS = $clog2(LINE_BYTES);
   localparam int SET_BITS = $clog2(SETS);
   localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int WAY_BITS = $clog2(WAYS);
   localparam int WAY_W    = (WAY_BITS > 0) ? WAY_BITS : 1;
   localparam int TAG_W    = satd_pkg::ADDR_W - OFF_BITS - SET_BITS;
   localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

   // Configuration registers
   logic                          idx_virt_ff;
   logic                          tag_virt_ff;
   logic [satd_pkg::POLICY_W-1:0] policy_ff;

   // Latched request
   logic [satd_pkg::REQ_TYPE_W-1:0] type_ff;
   logic [SET_W-1:0]                set_ff;
   logic [TAG_W-1:0]                tag_ff;
   logic [WAY_W-1:0]                wsel_ff;
   logic                            line_ok_ff;
   logic                            way_ok_ff;

   // Directory state
   logic [WAYS-1:0]  valid_ff [SETS];
   logic [TAG_W-1:0] rd_tag_ff [WAYS];
   logic [WAY_W-1:0] rr_ff, rr_in;
   logic [WAY_W-1:0] last_hit_ff, last_hit_in;
   logic [31:0]      lfsr_ff, lfsr_in;
   logic [satd_pkg::COUNT_W-1:0] hits_ff, hits_in;
   logic [satd_pkg::COUNT_W-1:0] misses_ff, misses_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [WAY_W-1:0] rsp_way_ff, rsp_way_in;

   // Lookup address split
   logic [satd_pkg::ADDR_W-1:0] iaddr, taddr;
   logic [SET_W-1:0]            lk_set;
   logic [TAG_W-1:0]            lk_tag;

   // Execute-cycle decisions
   logic             is_lookup;
   logic [WAYS-1:0]  hit_vec;
   logic             found;
   logic [WAY_W-1:0] hit_way;
   logic [31:0]      lfsr_step;
   logic [WAY_W-1:0] victim;
   logic             fill_en;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_virt_ff <= 1'b0;
         tag_virt_ff <= 1'b0;
         policy_ff   <= satd_pkg::POLICY_ROUND_ROBIN;
      end else if (csr_wr_en) begin
         case (csr_index)
            satd_pkg::CSR_INDEX_FROM_VIRT: idx_virt_ff <= csr_wr_data[0];
            satd_pkg::CSR_TAG_FROM_VIRT:   tag_virt_ff <= csr_wr_data[0];
            satd_pkg::CSR_REPLACE_POLICY:  policy_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Split the lookup address into set and tag
   assign iaddr  = idx_virt_ff ? req_virt_address : req_phys_address;
   assign taddr  = tag_virt_ff ? req_virt_address : req_phys_address;
   assign lk_set = SET_W'((iaddr >> OFF_BITS) & 32'(SETS - 1));
   assign lk_tag = TAG_W'(taddr >> (OFF_BITS + SET_BITS));

   // Latch the request on transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff    <= req_type;
         set_ff     <= (req_type == satd_pkg::REQ_LOOKUP) ? lk_set : SET_W'(req_set_select);
         tag_ff     <= lk_tag;
         wsel_ff    <= WAY_W'(req_way_select);
         way_ok_ff  <= (32'(req_way_select) < 32'(WAYS));
         line_ok_ff <= (32'(req_way_select) < 32'(WAYS)) && (32'(req_set_select) < 32'(SETS));
      end
   end

   // One tag memory per way: read on transfer, write on a miss fill
   for (genvar w = 0; w < WAYS; w++) begin : g_way
      logic [TAG_W-1:0] tag_mem [SETS];

      always_ff @(posedge clock) begin
         if (fill_en && (victim == WAY_W'(w))) begin
            tag_mem[set_ff] <= tag_ff;
         end
         if (cmd.capture) begin
            rd_tag_ff[w] <= tag_mem[lk_set];
         end
      end

      assign hit_vec[w] = valid_ff[set_ff][w] && (rd_tag_ff[w] == tag_ff);
   end

   // Pick the lowest matching way
   always_comb begin
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) hit_way = WAY_W'(w);
      end
   end

   assign found     = |hit_vec;
   assign is_lookup = (type_ff == satd_pkg::REQ_LOOKUP);
   assign fill_en   = cmd.execute && is_lookup && !found;
   assign lfsr_step = {1'b0, lfsr_ff[31:1]} ^ (lfsr_ff[0] ? satd_pkg::LFSR_TAPS : 32'h0);

   // Choose the victim and advance the policy state on a fill; record the hit way on a lookup hit
   always_comb begin
      victim      = '0;
      rr_in       = rr_ff;
      last_hit_in = last_hit_ff;
      lfsr_in     = lfsr_ff;
      case (policy_ff)
         satd_pkg::POLICY_ROUND_ROBIN: begin
            victim = rr_ff;
            rr_in  = (rr_ff == LAST_WAY) ? '0 : rr_ff + WAY_W'(1);
         end
         satd_pkg::POLICY_MRU_TOGGLE: begin
            victim      = (WAYS == 1 || last_hit_ff != '0) ? '0 : WAY_W'(1);
            last_hit_in = victim;
         end
         satd_pkg::POLICY_RANDOM: begin
            victim  = (WAYS == 1) ? '0 : WAY_W'(lfsr_step);
            lfsr_in = lfsr_step;
         end
         default: begin
            victim = '0;
         end
      endcase
      if (!fill_en) begin
         rr_in       = rr_ff;
         last_hit_in = last_hit_ff;
         lfsr_in     = lfsr_ff;
      end
      if (cmd.execute && is_lookup && found) begin
         last_hit_in = hit_way;
      end
   end

   // Counters and response fields
   assign hits_in    = (cmd.execute && is_lookup && found) ? hits_ff + 32'd1 : hits_ff;
   assign misses_in  = fill_en ? misses_ff + 32'd1 : misses_ff;
   assign rsp_hit_in = is_lookup && found;
   assign rsp_way_in = !is_lookup ? '0 : (found ? hit_way : victim);

   always_ff @(posedge clock) begin
      if (reset) begin
         rr_ff       <= '0;
         last_hit_ff <= '0;
         lfsr_ff     <= satd_pkg::LFSR_SEED;
         hits_ff     <= '0;
         misses_ff   <= '0;
      end else begin
         rr_ff       <= rr_in;
         last_hit_ff <= last_hit_in;
         lfsr_ff     <= lfsr_in;
         hits_ff     <= hits_in;
         misses_ff   <= misses_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_hit_ff <= rsp_hit_in;
         rsp_way_ff <= rsp_way_in;
      end
   end

   // Set or clear valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SETS; s++) valid_ff[s] <= '0;
      end else if (cmd.execute) begin
         case (type_ff)
            satd_pkg::REQ_LOOKUP: begin
               if (!found) valid_ff[set_ff][victim] <= 1'b1;
            end
            satd_pkg::REQ_FLUSH_ALL: begin
               for (int s = 0; s < SETS; s++) valid_ff[s] <= '0;
            end
            satd_pkg::REQ_INV_LINE: begin
               if (line_ok_ff) valid_ff[set_ff][wsel_ff] <= 1'b0;
            end
            satd_pkg::REQ_INV_WAY: begin
               if (way_ok_ff) begin
                  for (int s = 0; s < SETS; s++) valid_ff[s][wsel_ff] <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_hit        = rsp_hit_ff;
   assign rsp_way_used   = satd_pkg::WAY_OUT_W'(rsp_way_ff);
   assign rsp_hit_count  = hits_ff;
   assign rsp_miss_count = misses_ff;

endmodule

@@ design/set_assoc_cache_tag_directory.sv @@
// Top level of the set-associative cache tag directory: joins the controller
// and the datapath. Depends on satd_pkg, satd_ctrl and satd_datapath.
//
// Every request (lookup, flush all, invalidate line, invalidate way) is handled
// so: the accept edge reads one tag row from each way's memory, and
// the following cycle compares, fills or invalidates and registers the
// response, which shows on the rsp_ ports with rsp_valid for one cycle. A new
// request may be accepted in that same response cycle, but not while busy is
// high during execution. Results cannot be stalled. Valid bits are
// flip-flops, so a flush clears every set at once and reset needs no
// clearing pass. SETS, LINE_BYTES and WAYS must be powers of two; the block
// does not check this. Write configuration only while busy is low and no
// response is pending.
module set_assoc_cache_tag_directory #(
   parameter int SETS       = 64,
   parameter int WAYS       = 4,
   parameter int LINE_BYTES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [satd_pkg::REQ_TYPE_W-1:0]     req_type,
   input  logic [satd_pkg::ADDR_W-1:0]         req_phys_address,
   input  logic [satd_pkg::ADDR_W-1:0]         req_virt_address,
   input  logic [satd_pkg::WAY_SEL_W-1:0]      req_way_select,
   input  logic [satd_pkg::SET_SEL_W-1:0]      req_set_select,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [satd_pkg::WAY_OUT_W-1:0]      rsp_way_used,
   output logic [satd_pkg::COUNT_W-1:0]        rsp_hit_count,
   output logic [satd_pkg::COUNT_W-1:0]        rsp_miss_count,
   input  logic                                csr_wr_en,
   input  logic [satd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [satd_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   satd_pkg::cmd_type cmd;

   // Sequencer
   satd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Directory datapath
   satd_datapath #(
      .SETS       (SETS),
      .WAYS       (WAYS),
      .LINE_BYTES (LINE_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_type         (req_type),
      .req_phys_address (req_phys_address),
      .req_virt_address (req_virt_address),
      .req_way_select   (req_way_select),
      .req_set_select   (req_set_select),
      .rsp_hit          (rsp_hit),
      .rsp_way_used     (rsp_way_used),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_miss_count   (rsp_miss_count)
   );

`ifndef SYNTHESIS
   // A running request always produces its response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      busy && !reset |=> rsp_valid)
      else $error("busy cycle not followed by a response");

   // A response never overlaps execution of another request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // A hit advances the hit count by one and leaves the miss count alone
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |->
         rsp_hit_count == 32'($past(rsp_hit_count) + 32'd1) &&
         rsp_miss_count == $past(rsp_miss_count))
      else $error("hit response with wrong counts");

   // A response without a hit never moves the hit count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_count == $past(rsp_hit_count))
      else $error("hit count moved without a hit");
`endif

endmodule

@@ tb/sv/set_assoc_cache_tag_directory_tb.sv @@
`timescale 1ns / 1ps
// Testbench for set_assoc_cache_tag_directory: directed and random requests, each response
// checked against a scoreboard that tracks tags, valid bits, victim state and counts.
// Depends on satd_pkg and the set_assoc_cache_tag_directory design.
module set_assoc_cache_tag_directory_tb;

   localparam int SETS         = 64;
   localparam int WAYS         = 4;
   localparam int LINE_BYTES   = 64;
   localparam int ENTRIES      = SETS * WAYS;
   localparam int SET_BITS     = $clog2(SETS);
   localparam int OFFSET_BITS  = $clog2(LINE_BYTES);
   localparam int TAG_W        = satd_pkg::ADDR_W - SET_BITS - OFFSET_BITS;
   localparam int CLOCK_PERIOD = 4;
   localparam int RESET_CYCLES = 5;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 200;
   localparam int DRAIN_CYCLES = 4;
   localparam int TAG_POOL     = 6;

   // Policy code the block leaves unassigned: misses fill way 0
   localparam logic [satd_pkg::POLICY_W-1:0] POLICY_UNUSED = 2'd3;

   typedef struct packed {
      logic                           hit;
      logic [satd_pkg::WAY_OUT_W-1:0] way;
      logic [satd_pkg::COUNT_W-1:0]   hit_count;
      logic [satd_pkg::COUNT_W-1:0]   miss_count;
   } lookup_result_type;

   typedef struct packed {
      logic                          index_virt;
      logic                          tag_virt;
      logic [satd_pkg::POLICY_W-1:0] policy;
   } dir_setting_type;

   // Tracks the directory contents and holds the responses still due
   class directory_scoreboard_type;
      logic [TAG_W-1:0]              tag_mem [ENTRIES];
      bit                            valid_mem [ENTRIES];
      int                            mru_way;
      int                            rr_way;
      logic [31:0]                   lfsr;
      logic [satd_pkg::COUNT_W-1:0]  hits_total;
      logic [satd_pkg::COUNT_W-1:0]  misses_total;
      logic                          index_virt;
      logic                          tag_virt;
      logic [satd_pkg::POLICY_W-1:0] policy;
      lookup_result_type             results_due [$];
      int                            mismatches;
      int                            checked;
      int                            lookups;
      int                            maintenance;

      function new();
         foreach (valid_mem[i]) begin
            valid_mem[i] = 1'b0;
            tag_mem[i]   = '0;
         end
         mru_way      = 0;
         rr_way       = 0;
         lfsr         = satd_pkg::LFSR_SEED;
         hits_total   = '0;
         misses_total = '0;
         index_virt   = 1'b0;
         tag_virt     = 1'b0;
         policy       = satd_pkg::POLICY_ROUND_ROBIN;
         mismatches   = 0;
         checked      = 0;
         lookups      = 0;
         maintenance  = 0;
      endfunction

      function void write_reg(logic [satd_pkg::CSR_INDEX_W-1:0] index,
                              logic [satd_pkg::CSR_DATA_W-1:0] data);
         case (index)
            satd_pkg::CSR_INDEX_FROM_VIRT: index_virt = data[0];
            satd_pkg::CSR_TAG_FROM_VIRT:   tag_virt = data[0];
            satd_pkg::CSR_REPLACE_POLICY:  policy = data[satd_pkg::POLICY_W-1:0];
            default: ;
         endcase
      endfunction

      // Pick the way to fill on a miss and advance the policy state
      function int choose_victim();
         int way;
         way = 0;
         case (policy)
            satd_pkg::POLICY_ROUND_ROBIN: begin
               way    = rr_way % WAYS;
               rr_way = (way + 1) % WAYS;
            end
            satd_pkg::POLICY_MRU_TOGGLE: begin
               way     = (mru_way == 0 ? 1 : 0) % WAYS;
               mru_way = way;
            end
            satd_pkg::POLICY_RANDOM: begin
               lfsr = (lfsr >> 1) ^ ({32{lfsr[0]}} & satd_pkg::LFSR_TAPS);
               way  = int'(lfsr % WAYS);
            end
            default: way = 0;
         endcase
         return way;
      endfunction

      // Apply one accepted request and queue the response it must produce
      function void apply_request(logic [satd_pkg::REQ_TYPE_W-1:0] kind,
                                  logic [satd_pkg::ADDR_W-1:0] paddr,
                                  logic [satd_pkg::ADDR_W-1:0] vaddr,
                                  logic [satd_pkg::WAY_SEL_W-1:0] wsel,
                                  logic [satd_pkg::SET_SEL_W-1:0] ssel);
         logic [satd_pkg::ADDR_W-1:0] iaddr;
         logic [satd_pkg::ADDR_W-1:0] taddr;
         logic [TAG_W-1:0]            tag;
         int                          set_no;
         int                          way;
         int                          e;
         bit                          found;
         lookup_result_type           r;
         r     = '0;
         found = 1'b0;
         way   = 0;
         case (kind)
            satd_pkg::REQ_LOOKUP: begin
               lookups++;
               iaddr  = index_virt ? vaddr : paddr;
               taddr  = tag_virt ? vaddr : paddr;
               set_no = int'((iaddr / LINE_BYTES) % SETS);
               tag    = TAG_W'((taddr / LINE_BYTES) / SETS);
               // lowest matching valid way wins
               for (int w = 0; w < WAYS && !found; w++) begin
                  e = set_no + SETS * w;
                  if (valid_mem[e] && tag_mem[e] == tag) begin
                     found = 1'b1;
                     way   = w;
                  end
               end
               if (found) begin
                  mru_way = way;
                  hits_total++;
               end else begin
                  way          = choose_victim();
                  e            = set_no + SETS * way;
                  tag_mem[e]   = tag;
                  valid_mem[e] = 1'b1;
                  misses_total++;
               end
               r.hit = found;
               r.way = satd_pkg::WAY_OUT_W'(way);
            end
            satd_pkg::REQ_FLUSH_ALL: begin
               maintenance++;
               foreach (valid_mem[i]) valid_mem[i] = 1'b0;
            end
            satd_pkg::REQ_INV_LINE: begin
               maintenance++;
               if (int'(wsel) < WAYS && int'(ssel) < SETS)
                  valid_mem[int'(ssel) + SETS * int'(wsel)] = 1'b0;
            end
            satd_pkg::REQ_INV_WAY: begin
               maintenance++;
               if (int'(wsel) < WAYS)
                  for (int s = 0; s < SETS; s++) valid_mem[s + SETS * int'(wsel)] = 1'b0;
            end
            default: ;
         endcase
         r.hit_count  = hits_total;
         r.miss_count = misses_total;
         results_due.push_back(r);
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      // Compare one response transfer with the oldest one due
      function void compare_response(logic hit, logic [satd_pkg::WAY_OUT_W-1:0] way,
                                     logic [satd_pkg::COUNT_W-1:0] hc,
                                     logic [satd_pkg::COUNT_W-1:0] mc);
         lookup_result_type want;
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: hit=%0d way=%0d hits=%0d misses=%0d",
                        hit, way, hc, mc);
            return;
         end
         want = results_due.pop_front();
         checked++;
         if (hit !== want.hit || way !== want.way || hc !== want.hit_count ||
             mc !== want.miss_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("response %0d: expected hit=%0d way=%0d hits=%0d misses=%0d",
                        checked, want.hit, want.way, want.hit_count, want.miss_count);
               $display("response %0d: got      hit=%0d way=%0d hits=%0d misses=%0d",
                        checked, hit, way, hc, mc);
            end
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [satd_pkg::REQ_TYPE_W-1:0]  req_type;
   logic [satd_pkg::ADDR_W-1:0]      req_phys_address;
   logic [satd_pkg::ADDR_W-1:0]      req_virt_address;
   logic [satd_pkg::WAY_SEL_W-1:0]   req_way_select;
   logic [satd_pkg::SET_SEL_W-1:0]   req_set_select;
   logic                             rsp_valid;
   logic                             rsp_hit;
   logic [satd_pkg::WAY_OUT_W-1:0]   rsp_way_used;
   logic [satd_pkg::COUNT_W-1:0]     rsp_hit_count;
   logic [satd_pkg::COUNT_W-1:0]     rsp_miss_count;
   logic                             csr_wr_en;
   logic [satd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [satd_pkg::CSR_DATA_W-1:0]  csr_wr_data;

   directory_scoreboard_type         board;
   logic [TAG_W-1:0]                 tag_pool [TAG_POOL];
   int unsigned                      cycle_count = 0;

   set_assoc_cache_tag_directory #(
      .SETS       (SETS),
      .WAYS       (WAYS),
      .LINE_BYTES (LINE_BYTES)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_phys_address (req_phys_address),
      .req_virt_address (req_virt_address),
      .req_way_select   (req_way_select),
      .req_set_select   (req_set_select),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_way_used     (rsp_way_used),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_miss_count   (rsp_miss_count),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // End the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("set_assoc_cache_tag_directory_tb: errors");
         $finish;
      end
   end

   // Check every response transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         board.compare_response(rsp_hit, rsp_way_used, rsp_hit_count, rsp_miss_count);
   end

   // Present one request and hold it until the block takes it
   task automatic issue_request(input logic [satd_pkg::REQ_TYPE_W-1:0] kind,
                                input logic [satd_pkg::ADDR_W-1:0] paddr,
                                input logic [satd_pkg::ADDR_W-1:0] vaddr,
                                input logic [satd_pkg::WAY_SEL_W-1:0] wsel,
                                input logic [satd_pkg::SET_SEL_W-1:0] ssel);
      req_type         <= kind;
      req_phys_address <= paddr;
      req_virt_address <= vaddr;
      req_way_select   <= wsel;
      req_set_select   <= ssel;
      start            <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      board.apply_request(kind, paddr, vaddr, wsel, ssel);
   endtask

   // Drop start for a random number of cycles
   task automatic sender_gap(input int pct);
      if ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < pct);
      end
   endtask

   // Hold off new requests until every response has come back
   task automatic drain_responses();
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back once the block is idle
   task automatic apply_setting(input dir_setting_type s);
      logic [satd_pkg::CSR_INDEX_W-1:0] idx [3];
      logic [satd_pkg::CSR_DATA_W-1:0]  val [3];
      idx = '{satd_pkg::CSR_INDEX_FROM_VIRT, satd_pkg::CSR_TAG_FROM_VIRT,
              satd_pkg::CSR_REPLACE_POLICY};
      val = '{satd_pkg::CSR_DATA_W'(s.index_virt), satd_pkg::CSR_DATA_W'(s.tag_virt),
              satd_pkg::CSR_DATA_W'(s.policy)};
      drain_responses();
      csr_wr_en <= 1'b1;
      for (int k = 0; k < 3; k++) begin
         csr_index   <= idx[k];
         csr_wr_data <= val[k];
         @(posedge clock);
         board.write_reg(idx[k], val[k]);
      end
      csr_wr_en <= 1'b0;
   endtask

   // Mostly a few tags, often over a few sets, so lines hit, get evicted and come back
   function automatic logic [satd_pkg::ADDR_W-1:0] pick_address();
      int mode;
      logic [SET_BITS-1:0] set_no;
      mode = $urandom_range(0, 9);
      if (mode < 2) return $urandom();
      set_no = (mode < 6) ? SET_BITS'($urandom_range(0, 3))
                          : SET_BITS'($urandom_range(0, SETS - 1));
      return {tag_pool[$urandom_range(0, TAG_POOL - 1)], set_no,
              OFFSET_BITS'($urandom_range(0, LINE_BYTES - 1))};
   endfunction

   task automatic random_request();
      int pick;
      logic [satd_pkg::REQ_TYPE_W-1:0] kind;
      logic [satd_pkg::ADDR_W-1:0]     paddr;
      logic [satd_pkg::ADDR_W-1:0]     vaddr;
      pick  = $urandom_range(0, 99);
      kind  = pick < 86 ? satd_pkg::REQ_LOOKUP : pick < 88 ? satd_pkg::REQ_FLUSH_ALL :
              pick < 94 ? satd_pkg::REQ_INV_LINE : satd_pkg::REQ_INV_WAY;
      paddr = pick_address();
      vaddr = ($urandom_range(0, 2) == 0) ? paddr : pick_address();
      issue_request(kind, paddr, vaddr,
                    satd_pkg::WAY_SEL_W'($urandom_range(0, (1 << satd_pkg::WAY_SEL_W) - 1)),
                    satd_pkg::SET_SEL_W'($urandom_range(0, (1 << satd_pkg::SET_SEL_W) - 1)));
   endtask

   // Directed opening under the reset configuration
   task automatic run_directed();
      // cold miss, then hit, at both address extremes
      issue_request(satd_pkg::REQ_LOOKUP, '0, '0, '0, '0);
      issue_request(satd_pkg::REQ_LOOKUP, '0, '0, '0, '0);
      issue_request(satd_pkg::REQ_LOOKUP, '1, '1, '1, '1);
      issue_request(satd_pkg::REQ_LOOKUP, '1, '1, '1, '1);
      // overflow one set so round robin evicts, then revisit the evicted tag
      for (int k = 1; k <= WAYS + 1; k++)
         issue_request(satd_pkg::REQ_LOOKUP, {TAG_W'(k), SET_BITS'(5), OFFSET_BITS'(k)},
                       '1, '0, '0);
      issue_request(satd_pkg::REQ_LOOKUP, {TAG_W'(1), SET_BITS'(5), OFFSET_BITS'(0)},
                    '0, '0, '0);
      // drop single lines, whole ways and all lines, looking some of them up again
      issue_request(satd_pkg::REQ_INV_LINE, '1, '1, satd_pkg::WAY_SEL_W'(1), '1);
      issue_request(satd_pkg::REQ_LOOKUP, '1, '1, '0, '0);
      issue_request(satd_pkg::REQ_INV_WAY, '0, '0, '0, '0);
      issue_request(satd_pkg::REQ_LOOKUP, '0, '0, '1, '1);
      issue_request(satd_pkg::REQ_FLUSH_ALL, '1, '1, '1, '1);
      issue_request(satd_pkg::REQ_LOOKUP, '1, '1, '0, '0);
      issue_request(satd_pkg::REQ_INV_LINE, '0, '0, '1, '1);
      issue_request(satd_pkg::REQ_INV_WAY, '0, '0, '1, '0);
      issue_request(satd_pkg::REQ_INV_LINE, '1, '1, '0, '0);
      // physical and virtual addresses at opposite extremes
      issue_request(satd_pkg::REQ_LOOKUP, '0, '1, '0, '0);
      issue_request(satd_pkg::REQ_LOOKUP, '1, '0, '0, '0);
   endtask

   initial begin
      dir_setting_type settings [PHASE_COUNT];
      int idle_pct;
      board            = new();
      reset            = 1'b1;
      start            = 1'b0;
      req_type         = satd_pkg::REQ_LOOKUP;
      req_phys_address = '0;
      req_virt_address = '0;
      req_way_select   = '0;
      req_set_select   = '0;
      csr_wr_en        = 1'b0;
      csr_index        = satd_pkg::CSR_INDEX_FROM_VIRT;
      csr_wr_data      = '0;
      tag_pool[0]      = '0;
      tag_pool[1]      = '1;
      for (int k = 2; k < TAG_POOL; k++) tag_pool[k] = TAG_W'($urandom());
      settings = '{'{1'b0, 1'b0, satd_pkg::POLICY_ROUND_ROBIN},
                   '{1'b1, 1'b1, satd_pkg::POLICY_MRU_TOGGLE},
                   '{1'b0, 1'b1, satd_pkg::POLICY_RANDOM},
                   '{1'b1, 1'b0, POLICY_UNUSED},
                   '{1'b1, 1'b1, satd_pkg::POLICY_RANDOM},
                   '{1'b0, 1'b0, satd_pkg::POLICY_MRU_TOGGLE},
                   '{1'b0, 1'b0, satd_pkg::POLICY_ROUND_ROBIN},
                   '{1'b0, 1'b0, satd_pkg::POLICY_ROUND_ROBIN}};
      for (int p = PHASE_COUNT - 2; p < PHASE_COUNT; p++) begin
         settings[p].index_virt = $urandom_range(0, 1);
         settings[p].tag_virt   = $urandom_range(0, 1);
         settings[p].policy     =
            satd_pkg::POLICY_W'($urandom_range(0, (1 << satd_pkg::POLICY_W) - 1));
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // random phases: light sender idling, then heavy, then none
      for (int p = 0; p < PHASE_COUNT; p++) begin
         apply_setting(settings[p]);
         idle_pct = (p < 3) ? 22 : (p < 6) ? 79 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            sender_gap(idle_pct);
            if ($urandom_range(0, 99) == 0) drain_responses();
            random_request();
         end
      end

      drain_responses();
      repeat (2 * DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d lookups (%0d hits, %0d misses), %0d maintenance",
               board.checked, board.lookups, board.hits_total, board.misses_total,
               board.maintenance);
      $display("over %0d register settings and three sender idle profiles, %0d cycles",
               PHASE_COUNT, cycle_count);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("set_assoc_cache_tag_directory_tb: clean");
      end else begin
         $display("set_assoc_cache_tag_directory_tb: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/satd_pkg.sv
design/satd_ctrl.sv
design/satd_datapath.sv
design/set_assoc_cache_tag_directory.sv
tb/sv/set_assoc_cache_tag_directory_tb.sv
